// File: src/knsl_pkg.sv
`timescale 1ns / 1ps

package knsl_pkg;

    localparam int MAX_GROUP_DEF = 1024;
    localparam int MAX_RADIX_DEF = 32;

    // Register and field widths.
    localparam int GROUP_W  = 11;
    localparam int RADIX_W  = 6;
    localparam int MEMBER_W = 10;
    localparam int COUNT_W  = 6;
    localparam int EMIT_W   = 7;
    localparam int CFG_W    = 11;

    // The step stays below group size times radix, the offset below twice that.
    localparam int STEP_W = 17;
    localparam int OFF_W  = 18;

    localparam int RESULT_CAP = 62;

    localparam logic CFG_GROUP_SIZE = 1'b0;
    localparam logic CFG_RADIX      = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic advance;
        logic take;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic hit;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage

// File: src/knsl_ctrl.sv
`timescale 1ns / 1ps

module knsl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  knsl_pkg::t_status i_status,
    output logic             o_in_stall,
    output knsl_pkg::t_cmd   o_cmd
);

    knsl_pkg::t_state r_state;
    knsl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= knsl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            knsl_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = knsl_pkg::ST_WALK;
                end
            end
            knsl_pkg::ST_WALK: begin
                if (i_status.done) begin
                    n_state = knsl_pkg::ST_FINISH;
                end
            end
            knsl_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = knsl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = knsl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            knsl_pkg::ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.start = i_in_valid;
            end
            knsl_pkg::ST_WALK: begin
                if (!i_status.done) begin
                    if (i_status.hit) begin
                        // A new peer displaces the held one, which needs the output free.
                        if (!i_status.pend_valid || i_status.out_free) begin
                            o_cmd.take    = 1'b1;
                            o_cmd.advance = 1'b1;
                        end
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            knsl_pkg::ST_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == knsl_pkg::ST_IDLE && i_in_valid) |=> (r_state == knsl_pkg::ST_WALK))
        else $error("accepted request did not start a walk");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == knsl_pkg::ST_IDLE))
        else $error("final beat sent but controller not idle");

endmodule

// File: src/knsl_dpath.sv
`timescale 1ns / 1ps

module knsl_dpath #(
    parameter int MAX_GROUP = knsl_pkg::MAX_GROUP_DEF,
    parameter int MAX_RADIX = knsl_pkg::MAX_RADIX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [knsl_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [knsl_pkg::MEMBER_W-1:0] i_member_index,
    input  logic                          i_out_stall,
    input  knsl_pkg::t_cmd                i_cmd,
    output knsl_pkg::t_status             o_status,
    output logic                          o_out_valid,
    output logic [knsl_pkg::MEMBER_W-1:0] o_source_index,
    output logic [knsl_pkg::COUNT_W-1:0]  o_source_count,
    output logic                          o_last,
    output logic                          o_none_found
);

    localparam int GW = knsl_pkg::GROUP_W;
    localparam int KW = knsl_pkg::RADIX_W;
    localparam int SW = knsl_pkg::STEP_W;
    localparam int OW = knsl_pkg::OFF_W;
    localparam int MW = knsl_pkg::MEMBER_W;
    localparam int CW = knsl_pkg::COUNT_W;
    localparam int EW = knsl_pkg::EMIT_W;

    logic [GW-1:0] r_group_size;
    logic [KW-1:0] r_radix;

    logic [MW-1:0] r_member;
    logic [SW-1:0] r_step;
    logic [KW-1:0] r_digit;
    logic [OW-1:0] r_off;
    logic [EW-1:0] r_n;

    logic          r_pend_valid;
    logic [MW-1:0] r_pend_src;
    logic [CW-1:0] r_pend_cnt;

    logic          r_out_valid;
    logic [MW-1:0] r_out_src;
    logic [CW-1:0] r_out_cnt;
    logic          r_out_last;
    logic          r_out_none;

    logic [GW-1:0]    g_eff;
    logic [KW-1:0]    k_eff;
    logic [OW-1:0]    src_full;
    logic [KW-1:0]    n_digit;
    logic [SW+KW-1:0] step_prod;
    logic [EW-1:0]    n_count;
    logic             out_free;

    // Out-of-range settings saturate, and a radix below two walks as two.
    always_comb begin
        if ({{(32-GW){1'b0}}, r_group_size} > MAX_GROUP) begin
            g_eff = GW'(MAX_GROUP);
        end else begin
            g_eff = r_group_size;
        end
        if (r_radix < KW'(2)) begin
            k_eff = KW'(2);
        end else if ({{(32-KW){1'b0}}, r_radix} > MAX_RADIX) begin
            k_eff = KW'(MAX_RADIX);
        end else begin
            k_eff = r_radix;
        end
    end

    // A peer below the offset wraps round by the group size.
    always_comb begin
        if ({{(OW-MW){1'b0}}, r_member} >= r_off) begin
            src_full = {{(OW-MW){1'b0}}, r_member} - r_off;
        end else begin
            src_full = {{(OW-MW){1'b0}}, r_member} + {{(OW-GW){1'b0}}, g_eff} - r_off;
        end
    end

    assign n_digit   = r_digit + KW'(1);
    assign step_prod = r_step * k_eff;
    assign n_count   = r_n + EW'(1);
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_status.done       = (r_off >= {{(OW-GW){1'b0}}, g_eff}) ||
                                 (r_n == EW'(knsl_pkg::RESULT_CAP));
    assign o_status.hit        = src_full < {{(OW-GW){1'b0}}, g_eff};
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GW'(1);
            r_radix      <= KW'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                knsl_pkg::CFG_GROUP_SIZE: r_group_size <= i_cfg_data[GW-1:0];
                knsl_pkg::CFG_RADIX:      r_radix      <= i_cfg_data[KW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member <= '0;
            r_step   <= '0;
            r_digit  <= '0;
            r_off    <= '0;
            r_n      <= '0;
        end else if (i_cmd.start) begin
            r_member <= i_member_index;
            r_step   <= SW'(1);
            r_digit  <= KW'(1);
            r_off    <= OW'(1);
            r_n      <= '0;
        end else begin
            if (i_cmd.advance) begin
                if (n_digit >= k_eff) begin
                    r_digit <= KW'(1);
                    r_step  <= step_prod[SW-1:0];
                    r_off   <= OW'(step_prod);
                end else begin
                    r_digit <= n_digit;
                    r_off   <= r_off + {{(OW-SW){1'b0}}, r_step};
                end
            end
            if (i_cmd.take) begin
                r_n <= n_count;
            end
        end
    end

    // One peer is held back so that the last mark can go on the final beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.start || i_cmd.finish) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.take) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pend_src <= src_full[MW-1:0];
            r_pend_cnt <= n_count[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.take && r_pend_valid) || i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_src  <= r_pend_valid ? r_pend_src : '0;
            r_out_cnt  <= r_pend_valid ? r_pend_cnt : '0;
            r_out_last <= 1'b1;
            r_out_none <= !r_pend_valid;
        end else if (i_cmd.take && r_pend_valid) begin
            r_out_src  <= r_pend_src;
            r_out_cnt  <= r_pend_cnt;
            r_out_last <= 1'b0;
            r_out_none <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_source_index = r_out_src;
    assign o_source_count = r_out_cnt;
    assign o_last         = r_out_last;
    assign o_none_found   = r_out_none;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish || (i_cmd.take && r_pend_valid)) |-> out_free)
        else $error("output beat overwritten while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> (o_status.hit && !o_status.done))
        else $error("peer taken that the walk did not find");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= EW'(knsl_pkg::RESULT_CAP))
        else $error("peer count passed the result cap");

endmodule

// File: src/k_nomial_source_list_top.sv
`timescale 1ns / 1ps

// Lists, for one member index, the peers it polls in a k-nomial tree of the
// configured group size and radix, one beat per peer with a running count and
// a last mark; an empty list gives a single beat flagged none_found. One
// request at a time is handled: the walk tries one offset per cycle unless a
// found peer must wait for the held one to leave a stalled output, and a new
// request is taken only once the final beat of the last one is in the output
// register.
module k_nomial_source_list_top #(
    parameter int MAX_GROUP = knsl_pkg::MAX_GROUP_DEF,
    parameter int MAX_RADIX = knsl_pkg::MAX_RADIX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [knsl_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [knsl_pkg::MEMBER_W-1:0] i_member_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [knsl_pkg::MEMBER_W-1:0] o_source_index,
    output logic [knsl_pkg::COUNT_W-1:0]  o_source_count,
    output logic                          o_last,
    output logic                          o_none_found
);

    knsl_pkg::t_cmd    cmd;
    knsl_pkg::t_status status;

    knsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    knsl_dpath #(
        .MAX_GROUP (MAX_GROUP),
        .MAX_RADIX (MAX_RADIX)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_member_index (i_member_index),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_source_index (o_source_index),
        .o_source_count (o_source_count),
        .o_last         (o_last),
        .o_none_found   (o_none_found)
    );

endmodule

// File: tb/k_nomial_source_list_top_tb.sv
`timescale 1ns / 1ps

module k_nomial_source_list_top_tb;

    localparam int MAX_GROUP   = knsl_pkg::MAX_GROUP_DEF;
    localparam int MAX_RADIX   = knsl_pkg::MAX_RADIX_DEF;
    localparam int MEMBER_W    = knsl_pkg::MEMBER_W;
    localparam int COUNT_W     = knsl_pkg::COUNT_W;
    localparam int GROUP_W     = knsl_pkg::GROUP_W;
    localparam int RADIX_W     = knsl_pkg::RADIX_W;
    localparam int CFG_W       = knsl_pkg::CFG_W;
    localparam int RESULT_CAP  = knsl_pkg::RESULT_CAP;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 70;

    typedef struct packed {
        logic [MEMBER_W-1:0] source_index;
        logic [COUNT_W-1:0]  source_count;
        logic                last;
        logic                none_found;
    } t_peer_beat;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_index = knsl_pkg::CFG_GROUP_SIZE;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic [MEMBER_W-1:0] i_member_index = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [MEMBER_W-1:0] o_source_index;
    logic [COUNT_W-1:0]  o_source_count;
    logic                o_last;
    logic                o_none_found;

    k_nomial_source_list_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_member_index (i_member_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_source_index (o_source_index),
        .o_source_count (o_source_count),
        .o_last         (o_last),
        .o_none_found   (o_none_found)
    );

    always #5 i_clk = ~i_clk;

    // Requests waiting to be driven and peer beats waiting to arrive.
    logic [MEMBER_W-1:0] member_q[$];
    t_peer_beat          peer_expect_q[$];

    // Shadow of the registers.
    logic [GROUP_W-1:0]  model_group = 11'd1;
    logic [RADIX_W-1:0]  model_radix = 6'd2;

    int send_idle_pct = 24;
    int recv_idle_pct = 84;
    int error_count = 0;
    int requests_taken = 0;
    int beats_checked = 0;
    int empty_lists = 0;
    int settings_used = 0;
    int cycle_count = 0;

    // Walks the offsets d*step in order and queues one beat per peer in range.
    function automatic void list_sources(input logic [MEMBER_W-1:0] member);
        int unsigned g, k, step, dig, off, src, found;
        bit          walking;
        t_peer_beat  beat;
        g = model_group;
        k = model_radix;
        if (g > MAX_GROUP) g = MAX_GROUP;
        if (k < 2) k = 2;
        if (k > MAX_RADIX) k = MAX_RADIX;
        step = 1;
        dig = 1;
        off = 1;
        found = 0;
        walking = 1'b1;
        while (walking && found < RESULT_CAP) begin
            off = dig * step;
            if (off >= g) begin
                walking = 1'b0;
            end else begin
                if (member >= off) src = member - off;
                else src = member + g - off;
                if (src < g) begin
                    beat.source_index = src[MEMBER_W-1:0];
                    beat.source_count = COUNT_W'(found + 1);
                    beat.last = 1'b0;
                    beat.none_found = 1'b0;
                    peer_expect_q.push_back(beat);
                    found++;
                end
                dig++;
                if (dig >= k) begin
                    dig = 1;
                    step = step * k;
                end
            end
        end
        if (found == 0) begin
            beat = '{source_index: '0, source_count: '0, last: 1'b1, none_found: 1'b1};
            peer_expect_q.push_back(beat);
        end else begin
            peer_expect_q[peer_expect_q.size() - 1].last = 1'b1;
        end
    endfunction

    // Driver: a beat on the request side is taken when valid is high and stall low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                list_sources(i_member_index);
                requests_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (member_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_member_index <= member_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every accepted peer beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_peer_beat got, want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (o_out_valid && !i_out_stall) begin
                got = '{o_source_index, o_source_count, o_last, o_none_found};
                if (peer_expect_q.size() == 0) begin
                    $display("%0t: unexpected beat idx=%0d cnt=%0d last=%0b none=%0b",
                             $time, got.source_index, got.source_count, got.last,
                             got.none_found);
                    error_count++;
                end else begin
                    want = peer_expect_q.pop_front();
                    beats_checked++;
                    if (want.none_found) empty_lists++;
                    if (got.source_index !== want.source_index) begin
                        $display("%0t: source_index expected %0d actual %0d",
                                 $time, want.source_index, got.source_index);
                        error_count++;
                    end
                    if (got.source_count !== want.source_count) begin
                        $display("%0t: source_count expected %0d actual %0d",
                                 $time, want.source_count, got.source_count);
                        error_count++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, got.last);
                        error_count++;
                    end
                    if (got.none_found !== want.none_found) begin
                        $display("%0t: none_found expected %0b actual %0b",
                                 $time, want.none_found, got.none_found);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $time, peer_expect_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Waits until every request has been taken and every beat has come back.
    task automatic drain();
        while (member_q.size() > 0 || i_in_valid || peer_expect_q.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == knsl_pkg::CFG_GROUP_SIZE) model_group = value;
        else model_radix = value[RADIX_W-1:0];
    endtask

    // The radix register ignores the upper data bits, so they carry noise.
    task automatic set_tree(input int group, input int radix);
        drain();
        write_reg(knsl_pkg::CFG_GROUP_SIZE, CFG_W'(group));
        write_reg(knsl_pkg::CFG_RADIX, {5'($urandom_range(31)), RADIX_W'(radix)});
        settings_used++;
    endtask

    initial begin
        int g, r, limit_g;
        static int special_groups[5] = '{0, 1, 2, 1024, 2047};
        static int special_radix[5] = '{0, 1, 2, 32, 63};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values give a group of one, so every list is empty.
        member_q.push_back(10'd0);
        member_q.push_back(10'd1023);
        member_q.push_back(10'd517);

        set_tree(1024, 32);
        member_q.push_back(10'd0);
        member_q.push_back(10'd1023);
        member_q.push_back(10'd512);
        member_q.push_back(10'd31);
        set_tree(0, 2);
        member_q.push_back(10'd5);
        // Oversized group and radix saturate to the limits.
        set_tree(2047, 63);
        member_q.push_back(10'd1023);
        member_q.push_back(10'd0);
        // Radix below two behaves as two; members beyond the group skip peers.
        set_tree(7, 0);
        member_q.push_back(10'd6);
        member_q.push_back(10'd1023);
        set_tree(7, 1);
        member_q.push_back(10'd3);
        member_q.push_back(10'd200);
        set_tree(1000, 10);
        member_q.push_back(10'd999);
        member_q.push_back(10'd0);
        set_tree(2, 2);
        member_q.push_back(10'd0);
        member_q.push_back(10'd1);
        set_tree(33, 32);
        member_q.push_back(10'd32);
        member_q.push_back(10'd16);

        for (int s = 0; s < 24; s++) begin
            if (s == 8) begin
                drain();
                send_idle_pct = 84;
                recv_idle_pct = 24;
            end else if (s == 16) begin
                drain();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(7) == 0) g = special_groups[$urandom_range(4)];
            else if ($urandom_range(9) == 0) g = $urandom_range(2047, 1025);
            else if ($urandom_range(1) == 0) g = $urandom_range(64, 2);
            else g = $urandom_range(1024, 65);
            if ($urandom_range(5) == 0) r = special_radix[$urandom_range(4)];
            else r = $urandom_range(32, 2);
            set_tree(g, r);
            limit_g = (g > MAX_GROUP) ? MAX_GROUP : g;
            for (int n = 0; n < 17; n++) begin
                if (limit_g > 0 && $urandom_range(4) != 0)
                    member_q.push_back(MEMBER_W'($urandom_range(limit_g - 1)));
                else
                    member_q.push_back(MEMBER_W'($urandom()));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (peer_expect_q.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, peer_expect_q.size());
            error_count++;
        end
        $display("Covered %0d requests and %0d peer beats, %0d of them empty lists,",
                 requests_taken, beats_checked, empty_lists);
        $display("over %0d tree settings and three stall profiles.", settings_used);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
src/knsl_pkg.sv
src/knsl_ctrl.sv
src/knsl_dpath.sv
src/k_nomial_source_list_top.sv
tb/k_nomial_source_list_top_tb.sv
